/* design/dmx512_frame_receiver_defines.svh */
// ----------------------------------------------------------------------------
// DMX512 receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef DMX512_FRAME_RECEIVER_DEFINES_SVH
`define DMX512_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DMX_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DMX_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/dmx_pkg.sv */
// ----------------------------------------------------------------------------
// DMX512 receiver package
// Types and constants shared by the receiver modules.
// ----------------------------------------------------------------------------
package dmx_pkg;

   // Receiver modes as reported on the result channel.
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_IN_BREAK = 3'd1,
      MODE_IN_DATA  = 3'd2,
      MODE_COMPLETE = 3'd3,
      MODE_ERROR    = 3'd4
   } mode_type;

   // Kinds of input item.
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_ARM  = 2'd2;

   // Field widths.
   localparam int ACTION_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 9;
   localparam int PERIOD_W  = 16;
   localparam int TIMEOUT_W = 17;

   // Stream packing widths.
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 5;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TIMEOUT_PERIOD = 1'b0;
   localparam logic [PERIOD_W-1:0] TIMEOUT_PERIOD_RESET = 16'hFFFF;

   // One result item.
   typedef struct packed {
      mode_type               state;
      logic                   slot_write;
      logic [INDEX_W-1:0]     slot_index;
      logic [BYTE_W-1:0]      slot_value;
      logic                   frame_done;
      logic                   timeout_error;
   } rsp_type;

endpackage

/* design/dmx_csr.sv */
// ----------------------------------------------------------------------------
// DMX512 receiver register block
// APB-style access to the timeout period register.
// ----------------------------------------------------------------------------
module dmx_csr
   import dmx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [PERIOD_W-1:0]   timeout_period
);

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic                reg_sel;
   logic                wr_en;

   // Register index is the word address; byte offset bits are ignored.
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1] == REG_TIMEOUT_PERIOD);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready & reg_sel;

   // Next value of the period register.
   always_comb begin
      period_in = period_ff;
      if (wr_en) begin
         period_in = csr_pwdata[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TIMEOUT_PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // Read data, zero outside the register list.
   assign csr_prdata     = reg_sel ? {{(CSR_DATA_W-PERIOD_W){1'b0}}, period_ff}
                                   : '0;
   assign timeout_period = period_ff;

endmodule

/* design/dmx_core.sv */
// ----------------------------------------------------------------------------
// DMX512 receiver core
// Receiver state machine, slot and timeout counters, result formation.
// ----------------------------------------------------------------------------
`include "dmx512_frame_receiver_defines.svh"

module dmx_core
   import dmx_pkg::*;
#(
   parameter int SLOT_COUNT = 512
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [ACTION_W-1:0] action,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic                framing_error,
   input  logic [PERIOD_W-1:0] timeout_period,
   output rsp_type             result
);

   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   mode_type                mode_ff;
   mode_type                mode_in;
   logic [CNT_W-1:0]        slot_cnt_ff;
   logic [CNT_W-1:0]        slot_cnt_in;
   logic [CNT_W-1:0]        slot_inc;
   logic [TIMEOUT_W-1:0]    tmo_cnt_ff;
   logic [TIMEOUT_W-1:0]    tmo_cnt_in;
   logic [TIMEOUT_W-1:0]    tmo_inc;

   assign slot_inc = slot_cnt_ff + CNT_W'(1);
   assign tmo_inc  = tmo_cnt_ff + TIMEOUT_W'(1);

   // State registers update once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_COMPLETE;
         slot_cnt_ff <= '0;
         tmo_cnt_ff  <= '0;
      end else begin
         mode_ff     <= mode_in;
         slot_cnt_ff <= slot_cnt_in;
         tmo_cnt_ff  <= tmo_cnt_in;
      end
   end

   // Next state, counters and the result of the item on the input.
   always_comb begin
      mode_in              = mode_ff;
      slot_cnt_in          = slot_cnt_ff;
      tmo_cnt_in           = tmo_cnt_ff;
      result               = '0;
      result.state         = MODE_IDLE;
      if (push) begin
         unique case (action)
            ACT_ARM: begin
               mode_in = MODE_IDLE;
            end
            ACT_TICK: begin
               // Ticks only count during the data phase.
               if (mode_ff == MODE_IN_DATA) begin
                  tmo_cnt_in = tmo_inc;
                  if (tmo_inc > {1'b0, timeout_period}) begin
                     mode_in              = MODE_ERROR;
                     result.timeout_error = 1'b1;
                  end
               end
            end
            ACT_BYTE: begin
               unique case (mode_ff)
                  MODE_IDLE: begin
                     // A zero byte with a framing error marks a break.
                     if (framing_error && (rx_byte == '0)) begin
                        mode_in = MODE_IN_BREAK;
                     end
                  end
                  MODE_IN_BREAK: begin
                     // The first clean byte is the start code; it is dropped.
                     if (!framing_error) begin
                        mode_in     = MODE_IN_DATA;
                        slot_cnt_in = '0;
                        tmo_cnt_in  = '0;
                     end
                  end
                  MODE_IN_DATA: begin
                     result.slot_write = 1'b1;
                     result.slot_index = INDEX_W'(slot_cnt_ff);
                     result.slot_value = rx_byte;
                     slot_cnt_in       = slot_inc;
                     if (slot_inc >= CNT_W'(SLOT_COUNT)) begin
                        mode_in           = MODE_COMPLETE;
                        result.frame_done = 1'b1;
                     end
                  end
                  default: begin
                     // Bytes after the frame or after an error are ignored.
                  end
               endcase
            end
            default: begin
               // Unused action code leaves the state unchanged.
            end
         endcase
      end
      result.state = mode_in;
   end

   `DMX_ASSERT_IMPLY(a_done_is_complete, clock, reset,
      push && result.frame_done,
      result.slot_write && (mode_in == MODE_COMPLETE),
      "frame done without a last slot write")
   `DMX_ASSERT_IMPLY(a_tout_is_error, clock, reset,
      push && result.timeout_error,
      (mode_ff == MODE_IN_DATA) && (mode_in == MODE_ERROR),
      "timeout error outside the data phase")
   `DMX_ASSERT_NEXT(a_slot_advance, clock, reset,
      push && (action == ACT_BYTE) && (mode_ff == MODE_IN_DATA),
      slot_cnt_ff == $past(slot_cnt_ff) + CNT_W'(1),
      "slot counter did not advance on a data byte")
   `DMX_ASSERT_NEXT(a_arm_to_idle, clock, reset,
      push && (action == ACT_ARM),
      mode_ff == MODE_IDLE,
      "arm request did not return to idle")

endmodule

/* design/dmx_out_buf.sv */
// ----------------------------------------------------------------------------
// DMX512 receiver output buffer
// Result register with a skid stage so input and output stall independently.
// ----------------------------------------------------------------------------
`include "dmx512_frame_receiver_defines.svh"

module dmx_out_buf
   import dmx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type main_ff;
   rsp_type main_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    pop;

   assign pop        = main_valid_ff & out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   // Refill the result register from the skid stage first, then the input.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `DMX_ASSERT_IMPLY(a_skid_behind_main, clock, reset,
      skid_valid_ff, main_valid_ff,
      "skid stage holds a transfer while the result register is empty")
   `DMX_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && out_ready,
      !skid_valid_ff && (main_ff == $past(skid_ff)),
      "skid stage did not move into the result register")
   `DMX_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      push && main_valid_ff && !out_ready,
      skid_valid_ff,
      "stalled transfer was not kept in the skid stage")

endmodule

/* design/dmx512_frame_receiver.sv */
// ----------------------------------------------------------------------------
// DMX512 frame receiver
// Turns a UART byte, tick and arm stream into DMX512 slot writes.
// ----------------------------------------------------------------------------
// Each request transfer carries one event: a received byte with its framing
// error flag, a timer tick, or an arm request. Every request produces exactly
// one response transfer with the receiver mode after the event and, for data
// bytes, the slot index and value. An arm request returns the receiver to idle;
// a zero byte with a framing error is taken as a break, the next clean byte is
// the start code and is dropped, and the following SLOT_COUNT bytes are slot
// writes, the last one flagged with rsp_tlast. Ticks during the data phase
// raise a timeout error once they exceed timeout_period. After reset the
// receiver reports complete and waits for an arm request. The block takes one
// request per clock cycle while req_tready is high: the state update is a
// single combinational pass into a result register, and a skid stage lets the
// request side take one more request while the response side stalls.
// ----------------------------------------------------------------------------
module dmx512_frame_receiver
   import dmx_pkg::*;
#(
   parameter int SLOT_COUNT = 512
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] rx_byte
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] action, [2] framing_error
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [8:0] slot_index, [16:9] slot_value
   output logic                   rsp_tlast,  // frame_done
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // [2:0] receiver_state, [3] slot_write,
                                              // [4] timeout_error
   // Configuration port.
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [PERIOD_W-1:0] timeout_period;
   logic                push;
   rsp_type             core_result;
   rsp_type             out_result;

   assign push = req_tvalid & req_tready;

   // Register block.
   dmx_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .timeout_period (timeout_period)
   );

   // Receiver state machine.
   dmx_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .action         (req_tuser[ACTION_W-1:0]),
      .rx_byte        (req_tdata[BYTE_W-1:0]),
      .framing_error  (req_tuser[ACTION_W]),
      .timeout_period (timeout_period),
      .result         (core_result)
   );

   // Result register and skid stage.
   dmx_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (core_result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_result),
      .out_ready  (rsp_tready)
   );

   // Response packing.
   assign rsp_tdata = {{(RSP_TDATA_W-INDEX_W-BYTE_W){1'b0}},
                       out_result.slot_value, out_result.slot_index};
   assign rsp_tlast = out_result.frame_done;
   assign rsp_tuser = {out_result.timeout_error, out_result.slot_write,
                       out_result.state};

endmodule

/* test/dmx512_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// DMX512 frame receiver testbench
// Streams UART byte, tick and arm events into the receiver and checks every
// response transfer against a cycle-free prediction of the receiver modes,
// the slot writes, the end-of-frame flag and the timeout error. Directed
// events cover the corner cases first. Random frames follow with random
// timeout periods, random gaps on both streams and long response stalls now and then.
// ----------------------------------------------------------------------------
module dmx512_frame_receiver_test
   import dmx_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 512;
   localparam int ITEM_TARGET = 1950;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] PERIOD_ADDR = CSR_ADDR_W'(4 * REG_TIMEOUT_PERIOD);

   // One UART-side event as queued for the request stream.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   rx_byte;
      logic                framing_error;
   } uart_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [7:0] rx_byte
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // [1:0] action, [2] framing_error
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [8:0] slot_index, [16:9] slot_value
   logic                   rsp_tlast;        // frame_done
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // [2:0] receiver_state, [3] slot_write,
                                             // [4] timeout_error
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Events waiting to be sent and responses waiting to arrive.
   uart_item_type uart_stream_q[$];
   rsp_type       predicted_rsp_q[$];

   // Predicted receiver state and its copy of the timeout period.
   mode_type             rx_mode = MODE_COMPLETE;
   logic [9:0]           slot_count = '0;
   logic [TIMEOUT_W-1:0] tick_count = '0;
   logic [PERIOD_W-1:0]  period_cfg = TIMEOUT_PERIOD_RESET;

   int            queued_total = 0;
   int            mismatch_count = 0;
   bit            tx_gaps_on = 1'b0;
   bit            rx_stalls_on = 1'b0;
   int            tx_gap_left = 0;
   int            rx_stall_left = 0;
   int            rx_hold_left = 0;
   int            rsp_count = 0;
   uart_item_type next_item;
   rsp_type       oldest_rsp;

   dmx512_frame_receiver #(.SLOT_COUNT(SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Advances the predicted receiver by one event and returns its response.
   function automatic rsp_type advance_receiver(logic [ACTION_W-1:0] action,
                                                logic [BYTE_W-1:0] rx_byte,
                                                logic framing_error);
      rsp_type rsp;
      rsp = '0;
      case (action)
         ACT_ARM: begin
            rx_mode = MODE_IDLE;
         end
         ACT_TICK: begin
            if (rx_mode == MODE_IN_DATA) begin
               tick_count = tick_count + 1'b1;
               if (tick_count > {1'b0, period_cfg}) begin
                  rx_mode = MODE_ERROR;
                  rsp.timeout_error = 1'b1;
               end
            end
         end
         ACT_BYTE: begin
            case (rx_mode)
               MODE_IDLE: begin
                  // Only a zero byte with a framing error counts as a break.
                  if (framing_error && rx_byte == 8'h00) rx_mode = MODE_IN_BREAK;
               end
               MODE_IN_BREAK: begin
                  // The first clean byte is the start code and is dropped.
                  if (!framing_error) begin
                     rx_mode = MODE_IN_DATA;
                     slot_count = '0;
                     tick_count = '0;
                  end
               end
               MODE_IN_DATA: begin
                  rsp.slot_write = 1'b1;
                  rsp.slot_index = slot_count[INDEX_W-1:0];
                  rsp.slot_value = rx_byte;
                  slot_count = slot_count + 1'b1;
                  if (slot_count >= SLOTS) begin
                     rx_mode = MODE_COMPLETE;
                     rsp.frame_done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      rsp.state = rx_mode;
      return rsp;
   endfunction

   function automatic void flag_mismatch(string what, logic [31:0] exp_value,
                                         logic [31:0] act_value);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what,
                  exp_value, act_value);
   endfunction

   function automatic void compare_field(string what, logic [31:0] exp_value,
                                         logic [31:0] act_value);
      if (act_value !== exp_value) flag_mismatch(what, exp_value, act_value);
   endfunction

   // Gap lengths: mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_item(logic [ACTION_W-1:0] action, logic [BYTE_W-1:0] rx_byte,
                            logic framing_error);
      uart_stream_q.push_back('{action: action, rx_byte: rx_byte,
                                framing_error: framing_error});
      queued_total++;
   endtask

   // Random events of every kind, including the unused action code.
   task automatic queue_noise(int count);
      repeat (count)
         push_item(ACTION_W'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom));
   endtask

   // A well-formed frame: arm, break, start code, data bytes with ticks mixed in,
   // optionally preceded by bytes that idle and break must ignore.
   task automatic queue_frame(int data_len, int tick_pct);
      push_item(ACT_ARM, BYTE_W'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1)) push_item(ACT_BYTE, BYTE_W'($urandom_range(1, 255)), 1'b1);
         else push_item(ACT_BYTE, 8'h00, 1'b0);
      end
      push_item(ACT_BYTE, 8'h00, 1'b1);
      repeat ($urandom_range(0, 2)) push_item(ACT_BYTE, BYTE_W'($urandom), 1'b1);
      push_item(ACT_BYTE, BYTE_W'($urandom), 1'b0);
      repeat (data_len) begin
         if ($urandom_range(0, 99) < tick_pct)
            push_item(ACT_TICK, BYTE_W'($urandom), 1'($urandom));
         push_item(ACT_BYTE, BYTE_W'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   // Waits until no event is pending or in flight, then lets the clock run on as a margin.
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (uart_stream_q.size() != 0 || req_tvalid || predicted_rsp_q.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // Writes the timeout period and reads it back.
   task automatic program_period(logic [PERIOD_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= PERIOD_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      period_cfg = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      compare_field("timeout_period readback", CSR_DATA_W'(value), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Request driver: one event per transfer, predicted when it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_rsp_q.push_back(advance_receiver(req_tuser[1:0], req_tdata,
                                                       req_tuser[2]));
         if (!req_tvalid || req_tready) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_tvalid <= 1'b0;
            end else if (uart_stream_q.size() != 0) begin
               next_item = uart_stream_q.pop_front();
               req_tdata <= next_item.rx_byte;
               req_tuser <= {next_item.framing_error, next_item.action};
               req_tvalid <= 1'b1;
               tx_gap_left = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer and throttles rsp_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            // A long hold-off now and then lets the request side back up.
            if (rsp_count % 1000 == 300) rx_hold_left = 250;
            if (predicted_rsp_q.size() == 0) begin
               flag_mismatch("unexpected response", 32'h0, {rsp_tuser, rsp_tdata});
            end else begin
               oldest_rsp = predicted_rsp_q.pop_front();
               compare_field("receiver_state", oldest_rsp.state, rsp_tuser[2:0]);
               compare_field("slot_write", oldest_rsp.slot_write, rsp_tuser[3]);
               compare_field("timeout_error", oldest_rsp.timeout_error, rsp_tuser[4]);
               compare_field("slot_index", oldest_rsp.slot_index, rsp_tdata[8:0]);
               compare_field("slot_value", oldest_rsp.slot_value, rsp_tdata[16:9]);
               compare_field("frame_done", oldest_rsp.frame_done, rsp_tlast);
               compare_field("tdata padding", 32'h0, rsp_tdata[RSP_TDATA_W-1:17]);
            end
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 4) == 0) rx_stall_left = pick_gap();
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      int                  phase;
      int                  tick_pct;
      int                  data_len;
      logic [PERIOD_W-1:0] period;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corner cases from the reset state, which reports complete.
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
      push_item(ACT_BYTE, 8'h00, 1'b1);      // byte in complete is ignored
      push_item(ACT_TICK, 8'h5A, 1'b0);      // tick outside the data phase
      push_item(ACT_UNUSED, 8'hFF, 1'b1);    // unused action code
      push_item(ACT_ARM, 8'h00, 1'b0);
      push_item(ACT_ARM, 8'hA5, 1'b1);       // arm while already idle
      push_item(ACT_BYTE, 8'h00, 1'b0);      // zero byte without framing error
      push_item(ACT_BYTE, 8'h80, 1'b1);      // nonzero byte with framing error
      push_item(ACT_TICK, 8'h00, 1'b0);
      push_item(ACT_BYTE, 8'h00, 1'b1);      // break
      push_item(ACT_BYTE, 8'h7F, 1'b1);      // framing error during the break
      push_item(ACT_TICK, 8'h00, 1'b1);
      push_item(ACT_BYTE, 8'hCC, 1'b0);      // start code
      push_item(ACT_BYTE, 8'hFF, 1'b1);      // slot data, framing error ignored
      push_item(ACT_BYTE, 8'h00, 1'b0);
      push_item(ACT_TICK, 8'hFF, 1'b1);
      push_item(ACT_UNUSED, 8'h00, 1'b0);
      push_item(ACT_ARM, 8'hFF, 1'b1);       // abort the frame
      wait_until_quiet();

      // Zero period: the first tick in the data phase is an error.
      program_period('0);
      push_item(ACT_BYTE, 8'h00, 1'b1);
      push_item(ACT_BYTE, 8'h00, 1'b0);
      push_item(ACT_TICK, 8'h00, 1'b0);
      push_item(ACT_BYTE, 8'h12, 1'b0);      // byte in error is ignored
      push_item(ACT_TICK, 8'h00, 1'b0);
      push_item(ACT_ARM, 8'h00, 1'b0);
      wait_until_quiet();

      // Period lowered below the running tick count.
      program_period(16'd10);
      push_item(ACT_BYTE, 8'h00, 1'b1);
      push_item(ACT_BYTE, 8'h01, 1'b0);
      repeat (5) push_item(ACT_TICK, 8'h00, 1'b0);
      wait_until_quiet();
      program_period(16'd2);
      push_item(ACT_TICK, 8'h00, 1'b0);
      wait_until_quiet();

      // Random phases, each with its own period and idling pattern.
      phase = 0;
      while (queued_total < ITEM_TARGET) begin
         case (phase % 6)
            0: period = TIMEOUT_PERIOD_RESET;
            1: period = '0;
            2: period = PERIOD_W'($urandom_range(1, 8));
            3: period = PERIOD_W'($urandom_range(9, 64));
            4: period = PERIOD_W'($urandom_range(1000, 65534));
            default: period = PERIOD_W'($urandom);
         endcase
         tx_gaps_on = $urandom_range(0, 3) != 0;
         rx_stalls_on = $urandom_range(0, 3) != 0;
         program_period(period);
         tick_pct = (period < 64) ? $urandom_range(10, 40) : $urandom_range(0, 12);
         // Full frames only where the period cannot run out on the way.
         if (phase % 6 == 0 || phase % 6 == 4)
            queue_frame(SLOTS + $urandom_range(0, 3), tick_pct);
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 99) < 80) begin
               data_len = $urandom_range(0, 40);
               queue_frame(data_len, tick_pct);
            end else begin
               queue_noise($urandom_range(1, 10));
            end
         end
         wait_until_quiet();
         phase++;
      end

      if (mismatch_count == 0 && predicted_rsp_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Run-time limit, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/dmx_pkg.sv
design/dmx_csr.sv
design/dmx_core.sv
design/dmx_out_buf.sv
design/dmx512_frame_receiver.sv
test/dmx512_frame_receiver_test.sv
